[rtl/core/bpa_pkg.sv]
package bpa_pkg;

  localparam int MAX_PAGES_DEF  = 65536;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam int ADDR_W    = 48;
  localparam int PADDR_W   = 28;
  localparam int TOTAL_W   = 17;
  localparam int CNT_OUT_W = 17;
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_SEED    = 2'd2,
    OP_RESERVE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOFREE     = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_RANGE      = 3'd3,
    ST_DOUBLE     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_A_SUM,
    S_A_WORD,
    S_M_READ,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  function automatic logic [BIT_W-1:0] lowest_set64(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

[rtl/core/bpa_ram.sv]
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/bitmap_page_allocator.sv]
// Channel  Direction  Handshake              Fields
// in       input      in_valid / in_stall    opcode, phys_address
// out      output     out_valid / out_stall  page_address, status, free_count
// cfg      input      cfg_valid / cfg_ready  page_total
//
// Alloc steps: accept, top summary scan, summary word read, bitmap word read, commit; free,
// seed and reserve, double free included: accept, decode, word read, commit; misaligned frees,
// out-of-range items and alloc with an empty summary go from decode straight to finish.
// The steps follow the read-modify-write passes through the summary and bitmap RAMs.
// After reset the bitmap RAM is swept to all-used, one word a cycle, (MAX_PAGES+63)/64 words,
// 1024 at default; in_stall stays high during the sweep and while an item is in flight.
// Under out_stall a result holds the output register; the next item waits in finish
// together with its RAM writeback.
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           opcode,
  input  logic [ADDR_W-1:0]    phys_address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PADDR_W-1:0]   page_address,
  output logic [2:0]           status,
  output logic [CNT_OUT_W-1:0] free_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TOTAL_W-1:0]   page_total
);

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PIDX_W     = ADDR_W - PAGE_SHIFT;
  localparam int WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = WORD_COUNT > 1 ? $clog2(WORD_COUNT) : 1;
  localparam int SUM_COUNT  = (WORD_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int SUM_AW     = SUM_COUNT > 1 ? $clog2(SUM_COUNT) : 1;
  localparam int WI_W       = SUM_AW + BIT_W;
  localparam int PG_W       = WI_W + BIT_W;
  localparam int CNT_W      = $clog2(MAX_PAGES + 1);

  state_t state_q, state_next;

  logic [WORD_AW-1:0]   clr_cnt;
  logic [TOTAL_W-1:0]   page_total_q;
  opcode_t              op_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [WI_W-1:0]      widx_q;
  logic [BIT_W-1:0]     bpos_q;
  logic [WORD_BITS-1:0] sum_q;
  logic [WORD_BITS-1:0] word_new_q;
  logic [WORD_BITS-1:0] sum_new_q;
  logic                 commit_q;
  cnt_op_t              cnt_op_q;
  status_t              status_q;
  logic [PG_W-1:0]      page_q;
  logic [SUM_COUNT-1:0] top_nz;
  logic [CNT_W-1:0]     free_cnt;
  logic [CNT_W-1:0]     free_cnt_next;

  logic                 bm_we, sm_we;
  logic [WORD_AW-1:0]   bm_waddr, bm_raddr;
  logic [SUM_AW-1:0]    sm_waddr, sm_raddr;
  logic [WORD_BITS-1:0] bm_wdata, sm_wdata, word_rd, sum_rd;

  logic [PIDX_W-1:0]    pidx, total_c, pt_ext, max_ext;
  logic                 misaligned, out_of_range;
  logic                 top_any;
  logic [SUM_AW-1:0]    top_idx;
  logic [BIT_W-1:0]     sbit, fbit;
  logic [WI_W-1:0]      alloc_widx;
  logic [WORD_BITS-1:0] mask0, avail, word_new_c, sum_base, sum_new_c;
  logic [PG_W-1:0]      fpage;
  logic                 page_ok, cur_used, out_free, fin_go;
  logic [63:0]          pa_full;
  logic [31:0]          cnt_ext;

  bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(WORD_COUNT)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(word_rd)
  );

  bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(SUM_COUNT)) u_summary (
    .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
    .raddr(sm_raddr), .rdata(sum_rd)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_q != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign fin_go    = (state_q == S_FINISH) && out_free;

  assign pidx         = addr_q[ADDR_W-1:PAGE_SHIFT];
  assign misaligned   = |addr_q[PAGE_SHIFT-1:0];
  assign pt_ext       = PIDX_W'(page_total_q);
  assign max_ext      = PIDX_W'(MAX_PAGES);
  assign total_c      = (pt_ext > max_ext) ? max_ext : pt_ext;
  assign out_of_range = (pidx >= total_c);

  assign top_any = |top_nz;
  always_comb begin
    top_idx = '0;
    for (int i = SUM_COUNT - 1; i >= 0; i--) begin
      if (top_nz[i]) begin
        top_idx = SUM_AW'(i);
      end
    end
  end

  assign sbit       = lowest_set64(sum_rd);
  assign alloc_widx = {widx_q[WI_W-1:BIT_W], sbit};

  // page zero is never handed out
  assign mask0    = (widx_q == '0) ? ~WORD_BITS'(1) : '1;
  assign avail    = ~word_rd & mask0;
  assign fbit     = lowest_set64(avail);
  assign fpage    = {widx_q, fbit};
  assign page_ok  = (PIDX_W'(fpage) < total_c);
  assign cur_used = word_rd[bpos_q];

  always_comb begin
    if (state_q == S_A_WORD) begin
      word_new_c = word_rd | (WORD_BITS'(1) << fbit);
    end else if (op_q == OP_RESERVE) begin
      word_new_c = word_rd | (WORD_BITS'(1) << bpos_q);
    end else begin
      word_new_c = word_rd & ~(WORD_BITS'(1) << bpos_q);
    end
  end

  assign sum_base = (state_q == S_A_WORD) ? sum_q : sum_rd;
  always_comb begin
    sum_new_c = sum_base;
    sum_new_c[widx_q[BIT_W-1:0]] = |(~word_new_c & mask0);
  end

  always_comb begin
    case (cnt_op_q)
      CNT_INC: free_cnt_next = free_cnt + CNT_W'(1);
      CNT_DEC: free_cnt_next = free_cnt - CNT_W'(1);
      default: free_cnt_next = free_cnt;
    endcase
  end

  always_comb begin
    state_next = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_cnt == WORD_AW'(WORD_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (op_q == OP_ALLOC) begin
          state_next = top_any ? S_A_SUM : S_FINISH;
        end else if ((op_q == OP_FREE && misaligned) || out_of_range) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_M_READ;
        end
      end
      S_A_SUM:  state_next = S_A_WORD;
      S_A_WORD: state_next = S_FINISH;
      S_M_READ: state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = widx_q[WORD_AW-1:0];
    bm_wdata = word_new_q;
    bm_raddr = '0;
    sm_we    = 1'b0;
    sm_waddr = widx_q[WI_W-1:BIT_W];
    sm_wdata = sum_new_q;
    sm_raddr = '0;
    case (state_q)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_cnt;
        bm_wdata = '1;
        sm_we    = (32'(clr_cnt) < SUM_COUNT);
        sm_waddr = clr_cnt[SUM_AW-1:0];
        sm_wdata = '0;
      end
      S_DECODE: begin
        bm_raddr = pidx[WORD_AW+BIT_W-1:BIT_W];
        sm_raddr = (op_q == OP_ALLOC) ? top_idx : pidx[SUM_AW+2*BIT_W-1:2*BIT_W];
      end
      S_A_SUM: begin
        bm_raddr = alloc_widx[WORD_AW-1:0];
      end
      S_FINISH: begin
        bm_we = fin_go && commit_q;
        sm_we = fin_go && commit_q;
      end
      default: begin
        bm_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_q      <= S_CLEAR;
      clr_cnt      <= '0;
      page_total_q <= TOTAL_W'(65536);
      top_nz       <= '0;
      free_cnt     <= '0;
      out_valid    <= 1'b0;
    end else begin
      state_q <= state_next;
      if (state_q == S_CLEAR) begin
        clr_cnt <= clr_cnt + WORD_AW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        page_total_q <= page_total;
      end
      if (fin_go) begin
        out_valid <= 1'b1;
        if (commit_q) begin
          top_nz[widx_q[WI_W-1:BIT_W]] <= |sum_new_q;
          free_cnt                     <= free_cnt_next;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign pa_full = 64'(page_q) << PAGE_SHIFT;
  assign cnt_ext = 32'(commit_q ? free_cnt_next : free_cnt);

  always_ff @(posedge clk) begin
    case (state_q)
      S_IDLE: begin
        op_q   <= opcode_t'(opcode);
        addr_q <= phys_address;
      end
      S_DECODE: begin
        commit_q <= 1'b0;
        cnt_op_q <= CNT_KEEP;
        page_q   <= '0;
        status_q <= ST_OK;
        if (op_q == OP_ALLOC) begin
          widx_q[WI_W-1:BIT_W] <= top_idx;
          if (!top_any) begin
            status_q <= ST_NOFREE;
          end
        end else begin
          widx_q <= pidx[PG_W-1:BIT_W];
          bpos_q <= pidx[BIT_W-1:0];
          if (op_q == OP_FREE && misaligned) begin
            status_q <= ST_MISALIGNED;
          end else if (out_of_range) begin
            status_q <= ST_RANGE;
          end
        end
      end
      S_A_SUM: begin
        sum_q              <= sum_rd;
        widx_q[BIT_W-1:0]  <= sbit;
      end
      S_A_WORD: begin
        word_new_q <= word_new_c;
        sum_new_q  <= sum_new_c;
        if (page_ok) begin
          commit_q <= 1'b1;
          cnt_op_q <= CNT_DEC;
          page_q   <= fpage;
        end else begin
          status_q <= ST_NOFREE;
        end
      end
      S_M_READ: begin
        word_new_q <= word_new_c;
        sum_new_q  <= sum_new_c;
        case (op_q)
          OP_FREE: begin
            if (!cur_used) begin
              status_q <= ST_DOUBLE;
            end else begin
              commit_q <= 1'b1;
              cnt_op_q <= CNT_INC;
            end
          end
          OP_SEED: begin
            if (cur_used) begin
              commit_q <= 1'b1;
              cnt_op_q <= CNT_INC;
            end
          end
          OP_RESERVE: begin
            if (!cur_used) begin
              commit_q <= 1'b1;
              cnt_op_q <= CNT_DEC;
            end
          end
          default: begin
            commit_q <= 1'b0;
          end
        endcase
      end
      S_FINISH: begin
        if (out_free) begin
          page_address <= pa_full[PADDR_W-1:0];
          status       <= status_q;
          free_count   <= cnt_ext[CNT_OUT_W-1:0];
        end
      end
      default: begin
        commit_q <= commit_q;
      end
    endcase
  end

  a_count_dec: assert property (@(posedge clk) disable iff (rst)
    fin_go && commit_q && cnt_op_q == CNT_DEC |=> free_cnt == $past(free_cnt) - CNT_W'(1))
    else $error("free count not decremented on commit");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state_q) == S_FINISH)
    else $error("result raised outside finish");

  a_top_sync: assert property (@(posedge clk) disable iff (rst)
    fin_go && commit_q |=> top_nz[$past(widx_q[WI_W-1:BIT_W])] == $past(|sum_new_q))
    else $error("top summary out of step with summary word");

  a_summary_true: assert property (@(posedge clk) disable iff (rst)
    state_q == S_A_WORD |-> |avail)
    else $error("summary marked a full bitmap word as non-full");

endmodule
